// ===== hdl/fbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// fbfs_pkg: shared types and constants for the free block fit search
// Table depth, operation and fit mode codes, sequencer states and the
// candidate/pick records passed to the compare unit.
// ----------------------------------------------------------------------------
package fbfs_pkg;

  localparam int unsigned MaxBlocks = 16;
  localparam int unsigned SlotW     = $clog2(MaxBlocks);
  localparam int unsigned CntW      = $clog2(MaxBlocks + 1);
  localparam int unsigned SizeW     = 32;
  localparam int unsigned IdW       = 16;
  localparam int unsigned IndexW    = 4;
  localparam int unsigned OpW       = 2;
  localparam int unsigned ModeW     = 2;

  localparam logic [OpW-1:0] OpWrite = 2'd0;
  localparam logic [OpW-1:0] OpQuery = 2'd1;
  localparam logic [OpW-1:0] OpClear = 2'd2;

  localparam logic [ModeW-1:0] ModeFirst = 2'd0;
  localparam logic [ModeW-1:0] ModeBest  = 2'd1;
  localparam logic [ModeW-1:0] ModeWorst = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } fsm_state_e;

  typedef struct packed {
    logic             valid;
    logic [SizeW-1:0] size;
  } cand_t;

  typedef struct packed {
    logic             have;
    logic [SizeW-1:0] size;
  } pick_t;

endpackage

// ===== hdl/fbfs_fit_unit.sv =====
// ----------------------------------------------------------------------------
// fbfs_fit_unit: shared fit compare unit
// Decides whether the current table entry replaces the running pick under
// the selected fit rule.
// ----------------------------------------------------------------------------
module fbfs_fit_unit (
  input  logic [fbfs_pkg::ModeW-1:0] mode_i,
  input  logic [fbfs_pkg::SizeW-1:0] req_i,
  input  fbfs_pkg::cand_t            cand_i,
  input  fbfs_pkg::pick_t            pick_i,
  output logic                       take_o
);
  import fbfs_pkg::*;

  logic fits;
  logic smaller;
  logic larger;

  assign fits    = cand_i.valid && (cand_i.size >= req_i);
  assign smaller = cand_i.size < pick_i.size;
  assign larger  = cand_i.size > pick_i.size;

  always_comb begin
    case (mode_i)
      ModeFirst: take_o = fits && !pick_i.have;
      ModeBest:  take_o = fits && (!pick_i.have || smaller);
      // pick size starts at zero, so a zero-size block never wins
      ModeWorst: take_o = fits && larger;
      default:   take_o = 1'b0;
    endcase
  end

endmodule

// ===== hdl/free_block_fit_search.sv =====
// ----------------------------------------------------------------------------
// free_block_fit_search: first, best and worst fit over a free block table
//
// One input channel (in_valid_i/in_ready_o) carries write, clear and query
// transactions; one output channel (out_valid_o/out_ready_i) returns one
// result per query: a found flag and the chosen block id (0 if none).
// Write and clear take effect on acceptance and give no result. A query scans
// the table slot by slot through a single registered read port and one
// shared compare unit, then loads the output register in its final step;
// the block is not ready for a new transaction until that step is done.
// The result sits in an output register; the block accepts the next
// transaction while it waits. If the receiver stalls when a second query
// finishes, the block holds in its final step until the register frees.
// Reset clears all valid marks, the sequencer and the output register;
// sizes and ids are undefined until written.
// ----------------------------------------------------------------------------
module free_block_fit_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fbfs_pkg::OpW-1:0]    operation_i,
  input  logic [fbfs_pkg::IndexW-1:0] entry_index_i,
  input  logic [fbfs_pkg::SizeW-1:0]  entry_size_i,
  input  logic [fbfs_pkg::IdW-1:0]    entry_id_i,
  input  logic                        entry_valid_i,
  input  logic [fbfs_pkg::SizeW-1:0]  request_size_i,
  input  logic [fbfs_pkg::ModeW-1:0]  fit_mode_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [fbfs_pkg::IdW-1:0]    block_id_o
);
  import fbfs_pkg::*;

  fsm_state_e state_q, state_d;

  logic [SizeW-1:0]     size_mem [MaxBlocks];
  logic [IdW-1:0]       id_mem   [MaxBlocks];
  logic [MaxBlocks-1:0] valid_q;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SizeW-1:0] req_q;
  logic [ModeW-1:0] mode_q;
  logic             rd_vld_q;
  logic [SizeW-1:0] rd_size_q;
  logic [IdW-1:0]   rd_id_q;
  logic             have_q;
  logic [SizeW-1:0] pick_size_q;
  logic [IdW-1:0]   pick_id_q;
  logic             out_valid_q;
  logic             found_q;
  logic [IdW-1:0]   block_id_q;

  logic             accept;
  logic             start_scan;
  logic             do_write;
  logic             do_clear;
  logic             scan_last;
  logic             emit_load;
  logic             take;
  logic [SlotW-1:0] wr_addr;
  logic [SlotW-1:0] rd_addr;
  logic             rd_en;
  cand_t            cand;
  pick_t            pick;

  assign accept    = in_valid_i && in_ready_o;
  assign wr_addr   = SlotW'(entry_index_i);
  assign rd_addr   = cnt_q[SlotW-1:0];
  assign scan_last = (cnt_q == CntW'(MaxBlocks));
  assign rd_en     = (state_q == ST_SCAN) && !scan_last;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && operation_i == OpQuery) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SCAN: in_ready_o = 1'b0;
      ST_EMIT: emit_load  = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign start_scan = accept && (operation_i == OpQuery);
  assign do_write   = accept && (operation_i == OpWrite) &&
                      (32'(entry_index_i) < 32'(MaxBlocks));
  assign do_clear   = accept && (operation_i == OpClear);

  always_comb begin
    cnt_d = cnt_q;
    if (start_scan) begin
      cnt_d = '0;
    end else if (state_q == ST_SCAN && !scan_last) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // table storage, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      size_mem[wr_addr] <= entry_size_i;
      id_mem[wr_addr]   <= entry_id_i;
    end
    rd_size_q <= size_mem[rd_addr];
    rd_id_q   <= id_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (do_clear) begin
        valid_q <= '0;
      end else if (do_write) begin
        valid_q[wr_addr] <= entry_valid_i;
      end
      rd_vld_q <= rd_en && valid_q[rd_addr];
    end
  end

  assign cand.valid = rd_vld_q;
  assign cand.size  = rd_size_q;
  assign pick.have  = have_q;
  assign pick.size  = pick_size_q;

  fbfs_fit_unit u_fit (
    .mode_i (mode_q),
    .req_i  (req_q),
    .cand_i (cand),
    .pick_i (pick),
    .take_o (take)
  );

  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      req_q  <= request_size_i;
      mode_q <= fit_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      pick_size_q <= '0;
      pick_id_q   <= '0;
    end else if (start_scan) begin
      have_q      <= 1'b0;
      pick_size_q <= '0;
      pick_id_q   <= '0;
    end else if (state_q == ST_SCAN && take) begin
      have_q      <= 1'b1;
      pick_size_q <= rd_size_q;
      pick_id_q   <= rd_id_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      block_id_q  <= '0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
      found_q     <= have_q;
      block_id_q  <= pick_id_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign block_id_o  = block_id_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o)
    else $error("input ready while a query is in progress");

  a_query_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i == OpQuery) |=> state_q == ST_SCAN)
    else $error("accepted query did not start a scan");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> cnt_q <= CntW'(MaxBlocks))
    else $error("scan counter beyond table depth");

  a_miss_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> block_id_o == '0)
    else $error("non-zero block id on a miss");

endmodule
